// ===== rtl/smv_pkg.sv =====
package smv_pkg;

  localparam int DATA_W         = 32;
  localparam int VAR_INDEX_W    = 4;
  localparam int DEF_STACK_DEPTH = 16;
  localparam int DEF_VAR_SLOTS   = 16;

  typedef enum logic [2:0] {
    ACT_PUSH_IMM = 3'd0,
    ACT_PUSH_VAR = 3'd1,
    ACT_POP_VAR  = 3'd2,
    ACT_ADD      = 3'd3,
    ACT_SUB      = 3'd4,
    ACT_MUL      = 3'd5,
    ACT_DIV      = 3'd6,
    ACT_PRINT    = 3'd7
  } act_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_SHALLOW = 3'd1,
    ST_DIVZERO = 3'd2,
    ST_UNSET   = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;  // latch the instruction and read the stores
    logic exec;    // evaluate the instruction
    logic fin;     // commit the divide result
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_div;  // evaluated instruction is a valid divide
    logic div_done;  // divide unit has its quotient
  } dp_stat_t;

endpackage

// ===== rtl/smv_div.sv =====
module smv_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [smv_pkg::DATA_W-1:0]  dividend,
  input  logic [smv_pkg::DATA_W-1:0]  divisor,
  output logic                        done,
  output logic [smv_pkg::DATA_W-1:0]  quotient
);

  localparam int W  = smv_pkg::DATA_W;
  localparam int SW = $clog2(W);

  logic         running;
  logic [SW-1:0] step;
  logic         neg;
  logic [W-1:0] rem;
  logic [W-1:0] quo;
  logic [W-1:0] mag_d;
  logic [W:0]   shifted;
  logic [W+1:0] diff;

  // Trial subtract of one restoring step
  always_comb begin
    shifted = {rem, quo[W-1]};
    diff    = {1'b0, shifted} - {2'b00, mag_d};
  end

  // Control: count steps, pulse done after the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        step    <= '0;
      end else if (running) begin
        step <= step + SW'(1);
        if (step == SW'(W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // Datapath: magnitudes in, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      neg   <= dividend[W-1] ^ divisor[W-1];
      rem   <= '0;
      quo   <= dividend[W-1] ? (W'(0) - dividend) : dividend;
      mag_d <= divisor[W-1] ? (W'(0) - divisor) : divisor;
    end else if (running) begin
      rem <= diff[W+1] ? shifted[W-1:0] : diff[W-1:0];
      quo <= {quo[W-2:0], ~diff[W+1]};
    end
  end

  // Restore the sign; the most negative value over minus one wraps to itself
  assign quotient = neg ? (W'(0) - quo) : quo;

endmodule

// ===== rtl/smv_ctrl.sv =====
module smv_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  smv_pkg::dp_stat_t dp_stat,
  output smv_pkg::cmd_t     cmd,
  output logic              busy
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DIV
  } state_t;

  state_t state;

  // Decode commands from the current state
  always_comb begin
    cmd.accept = (state == S_IDLE) && start;
    cmd.exec   = (state == S_EXEC);
    cmd.fin    = (state == S_DIV) && dp_stat.div_done;
  end

  assign busy = (state != S_IDLE);

  // Sequence one instruction: read, evaluate, optionally divide
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) state <= S_EXEC;
        end
        S_EXEC: begin
          state <= dp_stat.need_div ? S_DIV : S_IDLE;
        end
        S_DIV: begin
          if (dp_stat.div_done) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> busy)
    else $error("accepted transfer did not raise busy");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    dp_stat.div_done |-> (state == S_DIV))
    else $error("divide finished outside the divide state");
`endif

endmodule

// ===== rtl/smv_dp.sv =====
module smv_dp #(
  parameter int STACK_DEPTH = smv_pkg::DEF_STACK_DEPTH,
  parameter int VAR_SLOTS   = smv_pkg::DEF_VAR_SLOTS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  smv_pkg::cmd_t                   cmd,
  input  logic [2:0]                      action,
  input  logic [smv_pkg::DATA_W-1:0]      imm_value,
  input  logic [smv_pkg::VAR_INDEX_W-1:0] var_index,
  output smv_pkg::dp_stat_t               dp_stat,
  output logic                            done,
  output logic [2:0]                      status,
  output logic [smv_pkg::DATA_W-1:0]      out_value
);

  localparam int W    = smv_pkg::DATA_W;
  localparam int AW   = $clog2(STACK_DEPTH);
  localparam int CW   = $clog2(STACK_DEPTH + 1);
  localparam int REACH = 1 << smv_pkg::VAR_INDEX_W;
  // Only slots that the index field can name get storage
  localparam int VU   = (VAR_SLOTS < REACH) ? VAR_SLOTS : REACH;
  localparam int VW   = (VU > 1) ? $clog2(VU) : 1;

  // Stores
  logic [W-1:0]  stk [STACK_DEPTH];
  logic [W-1:0]  vmem [VU];
  logic [VU-1:0] vvalid;
  logic [CW-1:0] count;

  // Latched instruction and registered read data
  smv_pkg::act_t act_q;
  logic [W-1:0]  imm_q;
  logic [VW-1:0] vaddr_q;
  logic          slot_ok_q;
  logic          vok_q;
  logic [W-1:0]  rd_a;
  logic [W-1:0]  rd_b;
  logic [W-1:0]  rd_v;

  logic          slot_ok;
  logic [VW-1:0] vaddr;
  logic [CW-1:0] cm1;
  logic [CW-1:0] cm2;
  logic          full;
  logic          empty;
  logic          lt2;

  smv_pkg::status_t ex_status;
  logic [W-1:0]     ex_value;
  logic             ex_push;
  logic             ex_pop;
  logic             ex_bin;
  logic             ex_vwr;
  logic [W-1:0]     mul_p;
  logic             commit;
  logic             res_valid;
  logic             div_done;
  logic [W-1:0]     div_q;

  assign slot_ok = ({{(32 - smv_pkg::VAR_INDEX_W){1'b0}}, var_index} < 32'(VAR_SLOTS));
  assign vaddr   = slot_ok ? var_index[VW-1:0] : '0;
  assign cm1     = count - CW'(1);
  assign cm2     = count - CW'(2);
  assign full    = (count == CW'(STACK_DEPTH));
  assign empty   = (count == '0);
  assign lt2     = (count < CW'(2));
  assign mul_p   = rd_a * rd_b;

  // Latch the instruction and read both stores on accept
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act_q     <= smv_pkg::act_t'(action);
      imm_q     <= imm_value;
      vaddr_q   <= vaddr;
      slot_ok_q <= slot_ok;
      vok_q     <= slot_ok && vvalid[vaddr];
      rd_b      <= stk[cm1[AW-1:0]];
      rd_a      <= stk[cm2[AW-1:0]];
      rd_v      <= vmem[vaddr];
    end
  end

  // Evaluate the latched instruction
  always_comb begin
    ex_status = smv_pkg::ST_OK;
    ex_value  = '0;
    ex_push   = 1'b0;
    ex_pop    = 1'b0;
    ex_bin    = 1'b0;
    ex_vwr    = 1'b0;
    case (act_q)
      smv_pkg::ACT_PUSH_IMM: begin
        if (full) begin
          ex_status = smv_pkg::ST_FULL;
        end else begin
          ex_value = imm_q;
          ex_push  = 1'b1;
        end
      end
      smv_pkg::ACT_PUSH_VAR: begin
        if (!vok_q) begin
          ex_status = smv_pkg::ST_UNSET;
        end else if (full) begin
          ex_status = smv_pkg::ST_FULL;
        end else begin
          ex_value = rd_v;
          ex_push  = 1'b1;
        end
      end
      smv_pkg::ACT_POP_VAR: begin
        if (empty) begin
          ex_status = smv_pkg::ST_SHALLOW;
        end else if (!slot_ok_q) begin
          ex_status = smv_pkg::ST_UNSET;
        end else begin
          ex_value = rd_b;
          ex_pop   = 1'b1;
          ex_vwr   = 1'b1;
        end
      end
      smv_pkg::ACT_PRINT: begin
        if (empty) begin
          ex_status = smv_pkg::ST_SHALLOW;
        end else begin
          ex_value = rd_b;
          ex_pop   = 1'b1;
        end
      end
      default: begin
        if (lt2) begin
          ex_status = smv_pkg::ST_SHALLOW;
        end else if (act_q == smv_pkg::ACT_DIV && rd_b == '0) begin
          ex_status = smv_pkg::ST_DIVZERO;
        end else begin
          ex_bin = 1'b1;
          case (act_q)
            smv_pkg::ACT_ADD: ex_value = rd_a + rd_b;
            smv_pkg::ACT_SUB: ex_value = rd_a - rd_b;
            smv_pkg::ACT_MUL: ex_value = mul_p;
            default:          ex_value = div_q;
          endcase
        end
      end
    endcase
  end

  assign dp_stat.need_div = (act_q == smv_pkg::ACT_DIV) && (ex_status == smv_pkg::ST_OK);
  assign dp_stat.div_done = div_done;

  assign res_valid = (cmd.exec && !dp_stat.need_div) || cmd.fin;
  assign commit    = res_valid && (ex_status == smv_pkg::ST_OK);

  // Update the stack and its count
  always_ff @(posedge clk) begin
    if (commit && ex_push) stk[count[AW-1:0]] <= ex_value;
    if (commit && ex_bin)  stk[cm2[AW-1:0]]   <= ex_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (commit) begin
      if (ex_push) count <= count + CW'(1);
      else if (ex_pop || ex_bin) count <= cm1;
    end
  end

  // Store into a variable slot and mark it set
  always_ff @(posedge clk) begin
    if (commit && ex_vwr) vmem[vaddr_q] <= ex_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vvalid <= '0;
    end else if (commit && ex_vwr) begin
      vvalid[vaddr_q] <= 1'b1;
    end
  end

  // Register the result transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      status    <= ex_status;
      out_value <= (ex_status == smv_pkg::ST_OK) ? ex_value : '0;
    end
  end

  smv_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.exec && dp_stat.need_div),
    .dividend (rd_a),
    .divisor  (rd_b),
    .done     (div_done),
    .quotient (div_q)
  );

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    commit && ex_push |-> !full)
    else $error("push committed on a full stack");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    done && (status != smv_pkg::ST_OK) |-> (out_value == '0))
    else $error("error result carries a nonzero value");

  a_err_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && (ex_status != smv_pkg::ST_OK) |=> $stable(count) && $stable(vvalid))
    else $error("failed instruction changed state");
`endif

endmodule

// ===== rtl/stack_machine_with_variables.sv =====
// Channel   Direction  Transfer                    Payload
// command   in         start && !busy at clk edge  action, imm_value, var_index
// result    out        done high for one cycle     status, out_value
//
// Push, pop, print, add, sub and mul latch the instruction on accept, evaluate
// it and register the result strobe; the next command is taken in the cycle
// the strobe shows. A div that passes its checks waits for the 32-step restoring
// divide unit; a div that fails its checks completes like the others.
// Reset (rst, synchronous) empties the stack and clears all variable valid bits.
// The receiver cannot stall: each result is shown for exactly one cycle.
module stack_machine_with_variables #(
  parameter int STACK_DEPTH = smv_pkg::DEF_STACK_DEPTH,
  parameter int VAR_SLOTS   = smv_pkg::DEF_VAR_SLOTS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [2:0]                             action,
  input  logic signed [smv_pkg::DATA_W-1:0]      imm_value,
  input  logic [smv_pkg::VAR_INDEX_W-1:0]        var_index,
  output logic                                   done,
  output logic [2:0]                             status,
  output logic signed [smv_pkg::DATA_W-1:0]      out_value
);

  smv_pkg::cmd_t                 cmd;
  smv_pkg::dp_stat_t             dp_stat;
  logic [smv_pkg::DATA_W-1:0]    value_u;

  smv_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .dp_stat (dp_stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  smv_dp #(
    .STACK_DEPTH (STACK_DEPTH),
    .VAR_SLOTS   (VAR_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .action    (action),
    .imm_value (imm_value),
    .var_index (var_index),
    .dp_stat   (dp_stat),
    .done      (done),
    .status    (status),
    .out_value (value_u)
  );

  assign out_value = $signed(value_u);

endmodule
